// ----- design/assert_macros.svh -----
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check on every edge outside reset
`define LWOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every edge, reset included
`define LWOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LWOC_ASSERT(lbl, prop, msg)
`define LWOC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- design/lwoc_pkg.sv -----
`timescale 1ns / 1ps

package lwoc_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_SYNC  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] object_id;
  } in_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic        hit;
    logic        fetch;
    logic        writeback;
    logic [31:0] writeback_id;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_SCAN,
    ST_ACC_LAST,
    ST_ACC_WR,
    ST_SYNC_FIND,
    ST_SYNC_EMIT
  } state_t;

endpackage

// ----- design/lwoc_mem.sv -----
`timescale 1ns / 1ps

module lwoc_mem (
  input  logic              clk,
  input  lwoc_pkg::mem_req_t req,
  output lwoc_pkg::entry_t  rdata
);
  import lwoc_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- design/lwoc_ctrl.sv -----
`timescale 1ns / 1ps

module lwoc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  lwoc_pkg::in_t      in_data,
  output logic               in_stall,
  output logic               res_valid,
  output lwoc_pkg::out_t     res,
  input  logic               res_ready,
  output lwoc_pkg::mem_req_t mem_req,
  input  lwoc_pkg::entry_t   rdata
);
  import lwoc_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  state_t state, state_next;

  logic              is_write;
  logic [31:0]       id;
  logic [SLOT_W-1:0] ptr;
  logic              ev;
  logic [SLOT_W-1:0] ev_idx;
  logic              hit_found;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] min_idx;
  logic [31:0]       min_stamp;
  logic [31:0]       min_tag;
  logic [SLOTS-1:0]  valid;
  logic [SLOTS-1:0]  dirty;
  logic [31:0]       next_stamp;

  logic [SLOTS-1:0]  vd;
  logic [SLOTS-1:0]  vd_rest;
  logic [SLOT_W-1:0] first_vd;
  logic [SLOT_W-1:0] first_free;
  logic              any_free;
  logic [SLOT_W-1:0] use_idx;
  logic              victim_wb;

  always_comb begin
    vd         = valid & dirty;
    vd_rest    = vd & ~(SLOTS'(1) << ptr);
    any_free   = ~&valid;
    first_vd   = '0;
    first_free = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vd[i]) begin
        first_vd = SLOT_W'(i);
      end
      if (!valid[i]) begin
        first_free = SLOT_W'(i);
      end
    end
    if (hit_found) begin
      use_idx = hit_idx;
    end else if (any_free) begin
      use_idx = first_free;
    end else begin
      use_idx = min_idx;
    end
    victim_wb = !hit_found && !any_free && dirty[min_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    res_valid     = 1'b0;
    res           = '0;
    mem_req       = '0;
    mem_req.raddr = ptr;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_data.mode inside {MODE_READ, MODE_WRITE}) begin
            state_next = ST_ACC_SCAN;
          end else if (in_data.mode == MODE_SYNC) begin
            state_next = ST_SYNC_FIND;
          end
        end
      end
      ST_ACC_SCAN: begin
        if (ptr == LAST_IDX) begin
          state_next = ST_ACC_LAST;
        end
      end
      ST_ACC_LAST: begin
        state_next = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        res_valid          = 1'b1;
        res.slot           = 6'(use_idx);
        res.hit            = hit_found;
        res.fetch          = !hit_found;
        res.writeback      = victim_wb;
        res.writeback_id   = victim_wb ? min_tag : 32'd0;
        res.last           = 1'b1;
        if (res_ready) begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = use_idx;
          mem_req.wdata.tag   = id;
          mem_req.wdata.stamp = next_stamp;
          state_next          = ST_IDLE;
        end
      end
      ST_SYNC_FIND: begin
        if (vd == '0) begin
          res_valid = 1'b1;
          res.last  = 1'b1;
          if (res_ready) begin
            state_next = ST_IDLE;
          end
        end else begin
          mem_req.raddr = first_vd;
          state_next    = ST_SYNC_EMIT;
        end
      end
      ST_SYNC_EMIT: begin
        res_valid        = 1'b1;
        res.slot         = 6'(ptr);
        res.writeback    = 1'b1;
        res.writeback_id = rdata.tag;
        res.last         = (vd_rest == '0);
        if (res_ready) begin
          state_next = (vd_rest == '0) ? ST_IDLE : ST_SYNC_FIND;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      dirty      <= '0;
      next_stamp <= '0;
      ev         <= 1'b0;
    end else begin
      ev <= (state == ST_ACC_SCAN);
      if (state == ST_ACC_WR && res_ready) begin
        valid[use_idx] <= 1'b1;
        dirty[use_idx] <= is_write || (hit_found && dirty[use_idx]);
        next_stamp     <= next_stamp + 32'd1;
      end
      if (state == ST_SYNC_EMIT && res_ready) begin
        dirty[ptr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx <= ptr;
    if (state == ST_IDLE && in_valid) begin
      id        <= in_data.object_id;
      is_write  <= (in_data.mode == MODE_WRITE);
      ptr       <= '0;
      hit_found <= 1'b0;
    end
    if (state == ST_ACC_SCAN) begin
      ptr <= ptr + SLOT_W'(1);
    end
    if (state == ST_SYNC_FIND && vd != '0) begin
      ptr <= first_vd;
    end
    if (ev) begin
      if (valid[ev_idx] && rdata.tag == id && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= ev_idx;
      end
      if (ev_idx == '0 || rdata.stamp < min_stamp) begin
        min_idx   <= ev_idx;
        min_stamp <= rdata.stamp;
        min_tag   <= rdata.tag;
      end
    end
  end

endmodule

// ----- design/lru_writeback_object_cache_top.sv -----
`timescale 1ns / 1ps
// Channel  Signals                         Transfer when
// -------  ------------------------------  ------------------------
// input    in_valid, in_stall, in_data     in_valid && !in_stall
// output   out_valid, out_stall, out_data  out_valid && !out_stall
//
// Read/write access: an accept state, a scan of the tag/stamp memory that reads
// one entry a cycle, a state for the last read to return, and a result state.
// Sync: an accept state, then a find state and a memory read state per dirty
// slot written back, or the empty result from the find state when nothing is
// dirty.
// Reset clears valid and dirty bits and the stamp counter; no clearing pass.
// A stalled output holds the control unit in its result state; the next item
// is taken once the previous result has moved into the output register.
`include "assert_macros.svh"

module lru_writeback_object_cache_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lwoc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lwoc_pkg::out_t out_data
);
  import lwoc_pkg::*;

  mem_req_t mem_req;
  entry_t   rdata;
  logic     res_valid;
  logic     res_ready;
  out_t     res;

  lwoc_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  lwoc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .mem_req   (mem_req),
    .rdata     (rdata)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  `LWOC_ASSERT(a_hit_xor_fetch, out_valid |-> !(out_data.hit && out_data.fetch), "hit with fetch")
  `LWOC_ASSERT(a_hit_no_wb, out_valid && out_data.hit |-> !out_data.writeback, "hit evicts")
  `LWOC_ASSERT(a_nowb_last, out_valid && !out_data.writeback |-> out_data.last, "plain not last")
  `LWOC_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !out_valid, "output valid after reset")

endmodule
